### src/rpr_pkg.sv
// Shared types, constants and build-time tables for the rotary position rotator.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rpr_pkg;

   localparam int EMBED_DIM     = 64;
   localparam int MAX_POSITIONS = 2048;
   localparam int FREQ_BASE     = 10000;
   localparam int CORDIC_STEPS  = 16;

   localparam int ROM_DEPTH   = 32;
   localparam int ATAN_DEPTH  = 24;
   localparam int NUM_STEPS   = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;

   localparam int POS_W       = 11;
   localparam int IDX_W       = 5;
   localparam int DATA_W      = 16;
   localparam int PHASE_W     = 32;
   localparam int SCALE_SH    = 16;
   localparam int DW          = 36;
   localparam int ZW          = 34;
   localparam int GAIN_W      = 32;
   localparam int HI_W        = DW - SCALE_SH;
   localparam int PH_W        = HI_W + GAIN_W + 1;
   localparam int PL_W        = SCALE_SH + GAIN_W;
   localparam int ACC_W       = PH_W + SCALE_SH + 1;
   localparam int OUT_SH      = 47;

   localparam logic OP_FORWARD  = 1'b0;
   localparam logic OP_BACKWARD = 1'b1;

   localparam logic [63:0] TURN_SCALE = 64'd2935890503282001226;

   typedef logic [31:0][63:0] rpr_chain_type;
   typedef logic [ROM_DEPTH-1:0][PHASE_W-1:0] rpr_rom_type;
   typedef logic [ATAN_DEPTH-1:0][PHASE_W-1:0] rpr_atan_type;

   typedef struct packed {
      logic                     valid;
      logic                     op;
      logic [PHASE_W-1:0]       phase;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } rpr_in_type;

   typedef struct packed {
      logic                 valid;
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
   } rpr_vec_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_arg;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Restoring long division, one quotient bit per iteration.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = (a >> 32) * b;
      lo = {32'd0, a[31:0]} * b;
      return (hi << 1) + (lo >> 31);
   endfunction

   function automatic logic [63:0] log2_base_q32();
      logic [63:0] b;
      logic [63:0] m;
      logic [63:0] frac;
      int          ip;
      b    = 64'(FREQ_BASE);
      frac = '0;
      ip   = 0;
      for (int n = 0; n < 40; n++) begin
         if (ip < 40 && (b >> (ip + 1)) != 64'd0) ip = ip + 1;
      end
      m = (b << 30) >> ip;
      for (int n = 0; n < 32; n++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 64'd1;
            m    = m >> 1;
         end
      end
      return (64'(ip) << 32) | frac;
   endfunction

   function automatic rpr_chain_type root_chain();
      rpr_chain_type rc;
      rc[0] = isqrt64(64'd1 << 61);
      for (int k = 1; k < 32; k++) begin
         rc[k] = isqrt64(rc[k-1] << 31);
      end
      return rc;
   endfunction

   function automatic logic [63:0] exp2_neg(input logic [63:0] f, input rpr_chain_type rc);
      logic [63:0] m;
      m = 64'd1 << 31;
      for (int k = 0; k < 32; k++) begin
         if (f[31-k]) m = (m * rc[k]) >> 31;
      end
      return m;
   endfunction

   function automatic rpr_rom_type build_phase_rom();
      rpr_rom_type   rom;
      rpr_chain_type rc;
      logic [63:0]   lb;
      logic [63:0]   e;
      logic [63:0]   v;
      logic [63:0]   sh;
      logic [63:0]   inc;
      rc = root_chain();
      lb = log2_base_q32();
      for (int i = 0; i < ROM_DEPTH; i++) begin
         e   = (lb * 64'd2 * 64'(i)) / 64'(EMBED_DIM);
         v   = mul_q31(TURN_SCALE, exp2_neg({32'd0, e[31:0]}, rc));
         sh  = 64'd32 + (e >> 32);
         inc = '0;
         if (sh < 64'd64) inc = (v + (64'd1 << (sh - 64'd1))) >> sh;
         rom[i] = inc[PHASE_W-1:0];
      end
      return rom;
   endfunction

   function automatic rpr_atan_type build_atan();
      rpr_atan_type tab;
      logic [63:0]  acc;
      logic [63:0]  t;
      logic [63:0]  rq;
      logic [63:0]  turns;
      int           sh;
      tab[0] = 32'd1 << 29;
      for (int k = 1; k < ATAN_DEPTH; k++) begin
         acc = '0;
         for (int n = 0; n < 32; n++) begin
            sh = k * (2 * n + 1);
            if (sh < 63) begin
               t = udiv64((64'd1 << 62) >> sh, 64'(2 * n + 1));
               if ((n & 1) != 0) acc = acc - t;
               else acc = acc + t;
            end
         end
         rq     = (acc + (64'd1 << 30)) >> 31;
         turns  = (mul_q31(TURN_SCALE, rq) + (64'd1 << 31)) >> 32;
         tab[k] = turns[PHASE_W-1:0];
      end
      return tab;
   endfunction

   function automatic logic [GAIN_W-1:0] build_inv_gain();
      logic [63:0] g;
      logic [63:0] s;
      g = 64'd1 << 31;
      for (int k = 0; k < NUM_STEPS; k++) begin
         s = isqrt64(((64'd1 << 31) + ((64'd1 << 31) >> (2 * k))) << 31);
         g = udiv64(g << 31, s);
      end
      return g[GAIN_W-1:0];
   endfunction

   localparam rpr_rom_type        PHASE_ROM  = build_phase_rom();
   localparam rpr_atan_type       ATAN_TABLE = build_atan();
   localparam logic [GAIN_W-1:0]  INV_GAIN   = build_inv_gain();

   // Rounds away the fraction of a gain product (already biased by one half)
   // and clamps it to the 16-bit result range.
   function automatic logic signed [DATA_W-1:0] sat_round(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-OUT_SH-1:0] t;
      logic signed [DATA_W-1:0]       res;
      t = acc[ACC_W-1:OUT_SH];
      if (!t[ACC_W-OUT_SH-1] && (|t[ACC_W-OUT_SH-2:DATA_W-1])) begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (t[ACC_W-OUT_SH-1] && !(&t[ACC_W-OUT_SH-2:DATA_W-1])) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = t[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### src/rotary_position_rotator_top.sv
// A request passes the input register, the pre-rotation register, a register per CORDIC step,
// the gain-product register and the response register before rsp_valid rises.
// Throughput: one transaction per cycle while the skid is empty; one CORDIC step per stage.
// A stalled output fills a one-entry skid register; req_ready drops only while it is full.
// Reset is synchronous and active high and clears all valid bits; no clearing pass is needed.
// Depends on rpr_pkg and rpr_cordic.
`timescale 1ns / 1ps
`default_nettype none

module rotary_position_rotator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [rpr_pkg::POS_W-1:0]         req_position,
   input  logic [rpr_pkg::IDX_W-1:0]         req_pair_index,
   input  logic signed [rpr_pkg::DATA_W-1:0] req_x_first,
   input  logic signed [rpr_pkg::DATA_W-1:0] req_x_second,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rpr_pkg::DATA_W-1:0] rsp_y_first,
   output logic signed [rpr_pkg::DATA_W-1:0] rsp_y_second
);
   import rpr_pkg::*;

   logic                      pipe_en;
   logic [POS_W+PHASE_W-1:0]  phase_prod;

   rpr_in_type                a_ff;
   rpr_vec_type               vec;

   logic                      m_valid_ff;
   logic signed [PH_W-1:0]    m_xh_ff;
   logic signed [PH_W-1:0]    m_yh_ff;
   logic [PL_W-1:0]           m_xl_ff;
   logic [PL_W-1:0]           m_yl_ff;

   logic signed [ACC_W-1:0]   acc_x;
   logic signed [ACC_W-1:0]   acc_y;
   logic signed [DATA_W-1:0]  res_x;
   logic signed [DATA_W-1:0]  res_y;

   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_x_ff;
   logic signed [DATA_W-1:0]  rsp_y_ff;
   logic                      skid_valid_ff;
   logic signed [DATA_W-1:0]  skid_x_ff;
   logic signed [DATA_W-1:0]  skid_y_ff;

   logic                      arrive;
   logic                      rsp_take;
   logic                      load_from_skid;
   logic                      load_new;
   logic                      load_skid;

   assign pipe_en   = !skid_valid_ff;
   assign req_ready = pipe_en;

   assign phase_prod = {{PHASE_W{1'b0}}, req_position}
                     * {{POS_W{1'b0}}, PHASE_ROM[req_pair_index]};

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_ff.op    <= req_op;
         a_ff.phase <= phase_prod[PHASE_W-1:0];
         a_ff.x     <= req_x_first;
         a_ff.y     <= req_x_second;
      end
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         a_ff.valid <= req_valid;
      end
   end

   rpr_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .enable (pipe_en),
      .vin    (a_ff),
      .vout   (vec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         m_valid_ff <= vec.valid;
      end
   end

   // The gain product is split into an upper signed and a lower unsigned partial product.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_xh_ff <= $signed(vec.x[DW-1:SCALE_SH]) * $signed({1'b0, INV_GAIN});
         m_yh_ff <= $signed(vec.y[DW-1:SCALE_SH]) * $signed({1'b0, INV_GAIN});
         m_xl_ff <= vec.x[SCALE_SH-1:0] * INV_GAIN;
         m_yl_ff <= vec.y[SCALE_SH-1:0] * INV_GAIN;
      end
   end

   always_comb begin
      acc_x = (ACC_W'(m_xh_ff) <<< SCALE_SH)
            + $signed({{(ACC_W-PL_W){1'b0}}, m_xl_ff})
            + (ACC_W'(1) <<< (OUT_SH - 1));
      acc_y = (ACC_W'(m_yh_ff) <<< SCALE_SH)
            + $signed({{(ACC_W-PL_W){1'b0}}, m_yl_ff})
            + (ACC_W'(1) <<< (OUT_SH - 1));
      res_x = sat_round(acc_x);
      res_y = sat_round(acc_y);
   end

   assign arrive         = pipe_en && m_valid_ff;
   assign rsp_take       = rsp_valid_ff && rsp_ready;
   assign load_from_skid = skid_valid_ff && rsp_take;
   assign load_new       = arrive && (!rsp_valid_ff || rsp_take);
   assign load_skid      = arrive && rsp_valid_ff && !rsp_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (load_from_skid || load_new) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load_skid) begin
            skid_valid_ff <= 1'b1;
         end else if (load_from_skid) begin
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_from_skid) begin
         rsp_x_ff <= skid_x_ff;
         rsp_y_ff <= skid_y_ff;
      end else if (load_new) begin
         rsp_x_ff <= res_x;
         rsp_y_ff <= res_y;
      end
      if (load_skid) begin
         skid_x_ff <= res_x;
         skid_y_ff <= res_y;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_y_first  = rsp_x_ff;
   assign rsp_y_second = rsp_y_ff;

endmodule

`default_nettype wire

### src/rpr_cordic.sv
// Quarter-turn pre-rotation followed by a pipelined CORDIC rotator, one step per stage.
// Depends on rpr_pkg for the arctangent table, widths and stage types.
`timescale 1ns / 1ps
`default_nettype none

module rpr_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  rpr_pkg::rpr_in_type vin,
   output rpr_pkg::rpr_vec_type vout
);
   import rpr_pkg::*;

   logic [PHASE_W-1:0]  phase;
   logic [PHASE_W-1:0]  quad_sum;
   logic [1:0]          quad;
   logic [PHASE_W-1:0]  resid;
   logic signed [DW-1:0] xs;
   logic signed [DW-1:0] ys;
   logic signed [DW-1:0] x_in;
   logic signed [DW-1:0] y_in;
   logic signed [ZW-1:0] z_in;

   logic                 v_ff [0:NUM_STEPS];
   logic signed [DW-1:0] x_ff [0:NUM_STEPS];
   logic signed [DW-1:0] y_ff [0:NUM_STEPS];
   logic signed [ZW-1:0] z_ff [0:NUM_STEPS-1];

   always_comb begin
      phase    = (vin.op == OP_BACKWARD) ? (PHASE_W'(0) - vin.phase) : vin.phase;
      quad_sum = phase + 32'h2000_0000;
      quad     = quad_sum[PHASE_W-1:PHASE_W-2];
      resid    = phase - {quad, {(PHASE_W-2){1'b0}}};
      z_in     = {{(ZW-PHASE_W){resid[PHASE_W-1]}}, resid};
      xs = {{(DW-DATA_W-SCALE_SH){vin.x[DATA_W-1]}}, vin.x, {SCALE_SH{1'b0}}};
      ys = {{(DW-DATA_W-SCALE_SH){vin.y[DATA_W-1]}}, vin.y, {SCALE_SH{1'b0}}};
      case (quad)
         2'd0: begin
            x_in = xs;
            y_in = ys;
         end
         2'd1: begin
            x_in = -ys;
            y_in = xs;
         end
         2'd2: begin
            x_in = -xs;
            y_in = -ys;
         end
         2'd3: begin
            x_in = ys;
            y_in = -xs;
         end
         default: begin
            x_in = xs;
            y_in = ys;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (enable) begin
         v_ff[0] <= vin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= z_in;
      end
   end

   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (enable) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[k][ZW-1]) begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
            end else begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
            end
         end
      end

      if (k < NUM_STEPS - 1) begin : g_angle
         always_ff @(posedge clock) begin
            if (enable) begin
               if (!z_ff[k][ZW-1]) begin
                  z_ff[k+1] <= z_ff[k] - $signed({{(ZW-PHASE_W){1'b0}}, ATAN_TABLE[k]});
               end else begin
                  z_ff[k+1] <= z_ff[k] + $signed({{(ZW-PHASE_W){1'b0}}, ATAN_TABLE[k]});
               end
            end
         end
      end
   end

   assign vout.valid = v_ff[NUM_STEPS];
   assign vout.x     = x_ff[NUM_STEPS];
   assign vout.y     = y_ff[NUM_STEPS];

endmodule

`default_nettype wire

### src/rpr_checker.sv
// Port-level checks for the rotary position rotator, bound to the top level.
// Depends on rotary_position_rotator_top and rpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [rpr_pkg::DATA_W-1:0] rsp_y_first,
   input logic signed [rpr_pkg::DATA_W-1:0] rsp_y_second
);

   // A result stalled by the consumer stays offered with the same data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_first) && $stable(rsp_y_second))
      else $error("Stalled response transaction changed or vanished.");

   // Reset empties the output side.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   // The input side is only held off while a result waits at the output.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("Request ready low with no response pending.");

   // A consumer that keeps taking results never causes the input side to stall.
   a_ready_kept: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_ready |=> req_ready)
      else $error("Request ready dropped while responses were being taken.");

   // Leaving reset with no request offered does not bring a result onto the output.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_valid |=> !rsp_valid)
      else $error("Response transaction without a request.");

endmodule

bind rotary_position_rotator_top rpr_checker u_rpr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_y_first  (rsp_y_first),
   .rsp_y_second (rsp_y_second)
);

`default_nettype wire
